// ===== rtl/core/bayer_bggr_bilinear_demosaic_macros.svh =====
// assertion macros for the bayer demosaic core
// expects clk and rst in the scope where a macro is used
`ifndef BAYER_BGGR_BILINEAR_DEMOSAIC_MACROS_SVH
`define BAYER_BGGR_BILINEAR_DEMOSAIC_MACROS_SVH

// same-cycle implication, disabled in reset
`define BBD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bbd_pkg.sv =====
// shared types and constants for the bayer demosaic core
// no dependencies
package bbd_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int OUT_COL_W  = 10;
  localparam int MIN_SIZE   = 3;
  localparam int HEIGHT_CAP = 1024;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd316;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd208;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // 3x3 neighbourhood, [row][column], row 0 is the oldest line
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic odd_row;
    logic odd_col;
  } phase_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

endpackage

// ===== rtl/core/bbd_interp.sv =====
// bilinear colour reconstruction for one 3x3 window centre
// depends on bbd_pkg
module bbd_interp import bbd_pkg::*; (
  input  win_t   window,
  input  phase_t phase,
  output rgb_t   color
);

  logic [PIX_W+1:0] cross_sum;
  logic [PIX_W+1:0] diag_sum;
  logic [PIX_W:0]   horiz_sum;
  logic [PIX_W:0]   vert_sum;
  logic [PIX_W-1:0] centre, cross_avg, diag, horiz, vert;

  always_comb begin
    centre    = window[1][1];
    cross_sum = (PIX_W+2)'(window[1][0]) + (PIX_W+2)'(window[1][2])
              + (PIX_W+2)'(window[0][1]) + (PIX_W+2)'(window[2][1]);
    diag_sum  = (PIX_W+2)'(window[0][0]) + (PIX_W+2)'(window[0][2])
              + (PIX_W+2)'(window[2][0]) + (PIX_W+2)'(window[2][2]);
    horiz_sum = (PIX_W+1)'(window[1][0]) + (PIX_W+1)'(window[1][2]);
    vert_sum  = (PIX_W+1)'(window[0][1]) + (PIX_W+1)'(window[2][1]);
    cross_avg = cross_sum[PIX_W+1:2];
    diag      = diag_sum[PIX_W+1:2];
    horiz     = horiz_sum[PIX_W:1];
    vert      = vert_sum[PIX_W:1];

    if (phase.odd_row) begin
      if (phase.odd_col) begin
        // red site
        color = '{blue: diag, green: cross_avg, red: centre};
      end else begin
        // green site on a red row
        color = '{blue: vert, green: centre, red: horiz};
      end
    end else begin
      if (phase.odd_col) begin
        // green site on a blue row
        color = '{blue: horiz, green: centre, red: vert};
      end else begin
        // blue site
        color = '{blue: centre, green: cross_avg, red: diag};
      end
    end
  end

endmodule

// ===== rtl/core/bayer_bggr_bilinear_demosaic.sv =====
// bggr bilinear demosaic top level; depends on bbd_pkg, bbd_interp and the macros header
// path: pixel request -> stage b -> result register (stage c) -> result port
// throughput: one pixel per cycle unless stalled; a centre at an edge gives up to four
// results, one per unstalled cycle off the result register, while the pixel side waits
// reset: sizes go to 316x208 and counters to zero; line stores and window are not cleared
`include "bayer_bggr_bilinear_demosaic_macros.svh"

module bayer_bggr_bilinear_demosaic import bbd_pkg::*; #(
  parameter int MAX_LINE = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  // raw pixel channel
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  logic [PIX_W-1:0]     raw_sample,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [PIX_W-1:0]     blue_out,
  output logic [PIX_W-1:0]     green_out,
  output logic [PIX_W-1:0]     red_out,
  output logic [OUT_COL_W-1:0] column_out,
  output logic [ROW_W-1:0]     row_out,
  output logic                 run_last
);

  localparam int AW = $clog2(MAX_LINE);      // column counter and line store address
  localparam int WW = $clog2(MAX_LINE + 1);  // effective width, may equal MAX_LINE

  // ---------------------------------------------------------------------------
  // frame size registers and clamping to the legal range
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [12:0]       fw_ext;
  logic [12:0]       w_sat;
  logic [WW-1:0]     w_eff;
  logic [SIZE_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = 13'(frame_width);
    if (fw_ext < 13'(MIN_SIZE)) begin
      w_sat = 13'(MIN_SIZE);
    end else if (fw_ext > 13'(MAX_LINE)) begin
      w_sat = 13'(MAX_LINE);
    end else begin
      w_sat = fw_ext;
    end
    w_eff = WW'(w_sat);

    if (frame_height < SIZE_W'(MIN_SIZE)) begin
      h_eff = SIZE_W'(MIN_SIZE);
    end else if (frame_height > SIZE_W'(HEIGHT_CAP)) begin
      h_eff = SIZE_W'(HEIGHT_CAP);
    end else begin
      h_eff = frame_height;
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: the whole pipe moves when the result register is free or
  // its final result of the run is being taken
  // ---------------------------------------------------------------------------
  logic c_valid;
  logic advance;
  logic pixel_take;
  logic result_take;

  assign result_take = result_valid && !result_stall;
  assign advance     = !c_valid || (result_take && run_last);
  assign pixel_stall = !advance;
  assign pixel_take  = pixel_valid && advance;

  // ---------------------------------------------------------------------------
  // raster position of the next incoming pixel
  // ---------------------------------------------------------------------------
  logic [AW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic             col_wrap;
  logic             row_wrap;

  assign col_wrap = (WW'(col_count) + WW'(1)) >= w_eff;
  assign row_wrap = (SIZE_W'(row_count) + SIZE_W'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      // any size change restarts the frame
      col_count <= '0;
      row_count <= '0;
    end else if (pixel_take) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + AW'(1);
      end
    end
  end

  // emission decode at request time: centre is one up and one left
  logic             emit;
  logic [AW-1:0]    centre_col;
  logic [ROW_W-1:0] centre_row;

  assign emit       = (col_count >= AW'(2)) && (row_count >= ROW_W'(2));
  assign centre_col = col_count - AW'(1);
  assign centre_row = row_count - ROW_W'(1);

  // ---------------------------------------------------------------------------
  // stage b: line store read data and the request's position flags
  // ---------------------------------------------------------------------------
  logic             b_valid;
  logic [PIX_W-1:0] b_sample;
  logic [AW-1:0]    b_col;
  logic [AW-1:0]    b_xc;
  logic [ROW_W-1:0] b_yc;
  logic             b_emit;
  phase_t           b_phase;
  logic             b_col_first, b_col_final;
  logic             b_row_first, b_row_final;
  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= pixel_take;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      b_sample    <= raw_sample;
      b_col       <= col_count;
      b_xc        <= centre_col;
      b_yc        <= centre_row;
      b_emit      <= emit;
      b_phase     <= '{odd_row: centre_row[0], odd_col: centre_col[0]};
      b_col_first <= centre_col == AW'(1);
      b_col_final <= WW'(centre_col) == (w_eff - WW'(2));
      b_row_first <= centre_row == ROW_W'(1);
      b_row_final <= SIZE_W'(centre_row) == (h_eff - SIZE_W'(2));
    end
  end

  // line stores: rows two above and one above the incoming row
  logic [PIX_W-1:0] upper_mem  [MAX_LINE];
  logic [PIX_W-1:0] middle_mem [MAX_LINE];

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      up_rd  <= upper_mem[col_count];
      mid_rd <= middle_mem[col_count];
    end
  end

  // write back from stage b at the previous column, so never the read address
  always_ff @(posedge clk) begin
    if (advance && b_valid) begin
      upper_mem[b_col]  <= mid_rd;
      middle_mem[b_col] <= b_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // window shift and colour reconstruction
  // ---------------------------------------------------------------------------
  win_t win;
  win_t win_next;
  rgb_t color_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = up_rd;
    win_next[1][2] = mid_rd;
    win_next[2][2] = b_sample;
  end

  always_ff @(posedge clk) begin
    if (advance && b_valid) begin
      win <= win_next;
    end
  end

  bbd_interp u_interp (
    .window (win_next),
    .phase  (b_phase),
    .color  (color_next)
  );

  // edge duplication lists: row then column order
  logic [ROW_W-1:0] row_list_next [3];
  logic [AW-1:0]    col_list_next [3];
  logic [1:0]       row_end_next;
  logic [1:0]       col_end_next;
  logic [ROW_W-1:0] row_last_val;
  logic [AW-1:0]    col_last_val;

  assign row_last_val = ROW_W'(h_eff - SIZE_W'(1));
  assign col_last_val = AW'(w_eff - WW'(1));

  always_comb begin
    row_list_next[0] = b_yc;
    row_list_next[1] = b_yc;
    row_list_next[2] = b_yc;
    row_end_next     = 2'd0;
    if (b_row_first) begin
      row_list_next[0] = '0;
      row_end_next     = 2'd1;
    end
    if (b_row_final) begin
      row_end_next                = row_end_next + 2'd1;
      row_list_next[row_end_next] = row_last_val;
    end

    col_list_next[0] = b_xc;
    col_list_next[1] = b_xc;
    col_list_next[2] = b_xc;
    col_end_next     = 2'd0;
    if (b_col_first) begin
      col_list_next[0] = '0;
      col_end_next     = 2'd1;
    end
    if (b_col_final) begin
      col_end_next                = col_end_next + 2'd1;
      col_list_next[col_end_next] = col_last_val;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: result register, walked one result per unstalled cycle
  // ---------------------------------------------------------------------------
  rgb_t             c_color;
  logic [ROW_W-1:0] row_list [3];
  logic [AW-1:0]    col_list [3];
  logic [1:0]       row_end, col_end;
  logic [1:0]       sel_row, sel_col;
  logic [1:0]       sel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      sel_row   <= '0;
      sel_col   <= '0;
      sel_count <= '0;
    end else if (advance) begin
      c_valid   <= b_valid && b_emit;
      sel_row   <= '0;
      sel_col   <= '0;
      sel_count <= '0;
    end else if (result_take) begin
      // not the final result of the run here
      sel_count <= sel_count + 2'd1;
      if (sel_col == col_end) begin
        sel_col <= '0;
        sel_row <= sel_row + 2'd1;
      end else begin
        sel_col <= sel_col + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b_valid && b_emit) begin
      c_color  <= color_next;
      row_list <= row_list_next;
      col_list <= col_list_next;
      row_end  <= row_end_next;
      col_end  <= col_end_next;
    end
  end

  // at most four results per pixel; extra corner duplicates on narrow or short frames are dropped
  assign result_valid = c_valid;
  assign run_last     = (sel_count == 2'd3) || ((sel_row == row_end) && (sel_col == col_end));
  assign blue_out     = c_color.blue;
  assign green_out    = c_color.green;
  assign red_out      = c_color.red;
  assign column_out   = OUT_COL_W'(col_list[sel_col]);
  assign row_out      = row_list[sel_row];

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `BBD_ASSERT_IMPL(a_take_ends_run, c_valid && advance, result_take && run_last, "run unfinished")
  `BBD_ASSERT_IMPL(a_col_in_frame, 1'b1, WW'(col_count) < w_eff, "column counter outside frame")
  `BBD_ASSERT_IMPL(a_row_in_frame, 1'b1, SIZE_W'(row_count) < h_eff, "row counter outside frame")
  `BBD_ASSERT_NEXT(a_run_continues, result_take && !run_last, result_valid, "run cut short")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the bggr bilinear demosaic core
// depends on bbd_pkg and the bayer_bggr_bilinear_demosaic top level
module tb;
  import bbd_pkg::*;

  localparam int LINE_DEPTH   = 1024;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 10;   // pipeline is 2 deep, plus slack for edge repeats
  localparam int IDLE_LIMIT   = 4000; // cycles with no request moving before we give up
  localparam int MAX_REPORTS  = 10;
  localparam int RESULT_CAP   = 4;    // most pixels one input can release

  // one demosaiced pixel as it leaves the result port
  typedef struct packed {
    logic [PIX_W-1:0]     blue;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     red;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } rgb_pixel_t;

  // clock, reset and everything we drive start at known values
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic                 cfg_index = REG_FRAME_WIDTH;
  logic [SIZE_W-1:0]    cfg_data = '0;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  logic [PIX_W-1:0]     raw_sample = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [PIX_W-1:0]     blue_out;
  logic [PIX_W-1:0]     green_out;
  logic [PIX_W-1:0]     red_out;
  logic [OUT_COL_W-1:0] column_out;
  logic [ROW_W-1:0]     row_out;
  logic                 run_last;

  bayer_bggr_bilinear_demosaic #(
    .MAX_LINE(LINE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .raw_sample(raw_sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .blue_out(blue_out),
    .green_out(green_out),
    .red_out(red_out),
    .column_out(column_out),
    .row_out(row_out),
    .run_last(run_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor state: frame size, the two previous lines, the 3x3 neighbourhood
  // and the position that the next raw sample will land on
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] sim_width  = WIDTH_RESET;
  logic [SIZE_W-1:0] sim_height = HEIGHT_RESET;
  logic [PIX_W-1:0]  line_above2 [LINE_DEPTH];
  logic [PIX_W-1:0]  line_above1 [LINE_DEPTH];
  logic [PIX_W-1:0]  nbhd [3][3];  // [row][column], row 0 oldest
  int unsigned       next_col = 0;
  int unsigned       next_row = 0;

  rgb_pixel_t expected_pixels [$];

  // idling knobs, percent of cycles
  int unsigned pixel_gap_pct    = 0;
  int unsigned result_stall_pct = 0;

  // bookkeeping
  int mismatches      = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int sizes_applied   = 0;
  int idle_count      = 0;

  // sizes outside 3..cap are saturated by the core when used
  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v,
                                             input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the predictor by one raw sample and queue the pixels it releases
  function automatic void demosaic_pixel(input logic [PIX_W-1:0] sample);
    int unsigned w, h, c, r, xc, yc, nr, nc, n;
    int unsigned rows [3];
    int unsigned cols [3];
    int unsigned centre, plus_avg, diag_avg, horiz_avg, vert_avg, bl, gr, rd;
    rgb_pixel_t px;
    w = clamp_size(sim_width, LINE_DEPTH);
    h = clamp_size(sim_height, HEIGHT_CAP);
    c = next_col;
    r = next_row;

    // shift the window left and pull in the new column
    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = line_above2[c];
    nbhd[1][2] = line_above1[c];
    nbhd[2][2] = sample;
    line_above2[c] = line_above1[c];
    line_above1[c] = sample;

    if (c >= 2 && r >= 2 && c < w && r < h) begin
      xc = c - 1;
      yc = r - 1;
      centre    = nbhd[1][1];
      plus_avg  = (nbhd[1][0] + nbhd[1][2] + nbhd[0][1] + nbhd[2][1]) >> 2;
      diag_avg  = (nbhd[0][0] + nbhd[0][2] + nbhd[2][0] + nbhd[2][2]) >> 2;
      horiz_avg = (nbhd[1][0] + nbhd[1][2]) >> 1;
      vert_avg  = (nbhd[0][1] + nbhd[2][1]) >> 1;

      // bggr phase of the centre
      if (yc[0]) begin
        if (xc[0]) begin
          rd = centre;    gr = plus_avg; bl = diag_avg;   // red site
        end else begin
          rd = horiz_avg; gr = centre;   bl = vert_avg;   // green on a red row
        end
      end else begin
        if (xc[0]) begin
          rd = vert_avg;  gr = centre;   bl = horiz_avg;  // green on a blue row
        end else begin
          rd = diag_avg;  gr = plus_avg; bl = centre;     // blue site
        end
      end

      // edge pixels reuse the nearest inner centre
      nr = 0;
      nc = 0;
      if (yc == 1) begin rows[nr] = 0; nr++; end
      rows[nr] = yc; nr++;
      if (yc == h - 2) begin rows[nr] = h - 1; nr++; end
      if (xc == 1) begin cols[nc] = 0; nc++; end
      cols[nc] = xc; nc++;
      if (xc == w - 2) begin cols[nc] = w - 1; nc++; end

      // narrow or short frames can ask for more than the cap, the tail is dropped
      n = 0;
      for (int a = 0; a < nr; a++) begin
        for (int b = 0; b < nc; b++) begin
          if (n < RESULT_CAP) begin
            px.blue  = bl[PIX_W-1:0];
            px.green = gr[PIX_W-1:0];
            px.red   = rd[PIX_W-1:0];
            px.col   = cols[b][OUT_COL_W-1:0];
            px.row   = rows[a][ROW_W-1:0];
            px.last  = 1'b0;
            expected_pixels.push_back(px);
            n++;
          end
        end
      end
      if (n > 0) expected_pixels[expected_pixels.size()-1].last = 1'b1;
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endfunction

  // ---------------------------------------------------------------------------
  // pixel side
  // ---------------------------------------------------------------------------

  // offer one raw sample, with random gaps, and predict once it is taken
  task automatic send_pixel(input logic [PIX_W-1:0] s);
    while ($urandom_range(99) < pixel_gap_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    raw_sample  <= s;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    demosaic_pixel(s);
    pixels_sent++;
  endtask

  // random samples with the rails well represented
  task automatic send_samples(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) send_pixel('0);
      else if (pick == 1) send_pixel('1);
      else send_pixel(PIX_W'($urandom_range(255)));
    end
  endtask

  // drop valid, wait for every predicted pixel, then let the pipeline empty out
  task automatic drain_and_pause();
    pixel_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // configuration; only called with the core idle, each write restarts the frame
  // ---------------------------------------------------------------------------
  task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    sim_width = w;
    next_col  = 0;
    next_row  = 0;
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    sim_height = h;
    next_col   = 0;
    next_row   = 0;
    cfg_write <= 1'b0;
    sizes_applied++;
  endtask

  task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) sim_width = value;
    else sim_height = value;
    next_col = 0;
    next_row = 0;
    cfg_write <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned gap, input int unsigned stall);
    pixel_gap_pct    = gap;
    result_stall_pct = stall;
  endtask

  // ---------------------------------------------------------------------------
  // result side: compare each pixel taken with the oldest prediction, and
  // stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rgb_pixel_t want;
    rgb_pixel_t got;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got = '{blue_out, green_out, red_out, column_out, row_out, run_last};
        results_checked++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected pixel b=%0d g=%0d r=%0d col=%0d row=%0d last=%0b",
                     $realtime, got.blue, got.green, got.red, got.col, got.row, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: pixel mismatch", $realtime);
              $display("  expected b=%0d g=%0d r=%0d col=%0d row=%0d last=%0b",
                       want.blue, want.green, want.red, want.col, want.row, want.last);
              $display("  actual   b=%0d g=%0d r=%0d col=%0d row=%0d last=%0b",
                       got.blue, got.green, got.red, got.col, got.row, got.last);
            end
          end
        end
      end
      result_stall <= ($urandom_range(99) < result_stall_pct);
    end
  end

  // watchdog: nothing moving on any port for too long means a hang
  always @(posedge clk) begin
    if (rst || cfg_write || (pixel_valid && !pixel_stall) ||
        (result_valid && !result_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles, %0d pixels outstanding",
                 idle_count, expected_pixels.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // out of reset the core runs 316x208; the start of the first line gives no results
  task automatic test_reset_size();
    set_idling(0, 0);
    send_samples(24);
    drain_and_pause();
  endtask

  // smallest frames: rail values, all four colour phases, the four-result cap
  task automatic test_directed_extremes();
    set_idling(0, 0);
    // 3x3: a single centre that would fan out to nine pixels
    set_frame(11'd3, 11'd3);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd0 : 8'd255);
    drain_and_pause();
    // 4x4: each centre has a different bggr phase
    set_frame(11'd4, 11'd4);
    for (int i = 0; i < 16; i++)
      send_pixel(((i / 4 + i % 4) % 2) ? 8'd255 : PIX_W'(i * 17));
    drain_and_pause();
  endtask

  // a write in the middle of a frame restarts it, whichever register it hits
  task automatic test_frame_restart();
    set_idling(0, 0);
    set_frame(11'd5, 11'd4);
    send_samples(7);
    drain_and_pause();
    write_reg(REG_FRAME_WIDTH, 11'd5);
    send_samples(13);
    drain_and_pause();
    write_reg(REG_FRAME_HEIGHT, 11'd4);
    send_samples(20);
    drain_and_pause();
  endtask

  // widest and tallest frames through saturated register values, first lines only
  task automatic test_size_limits();
    set_idling(0, 0);
    set_frame('1, 11'd2);      // 1024 wide, 3 high
    send_samples(24);
    drain_and_pause();
    set_frame('0, '1);         // 3 wide, 1024 high
    send_samples(36);
    drain_and_pause();
  endtask

  // mostly whole frames of random size and content, some of them back to back,
  // with a share of cut-short frames and saturated sizes
  task automatic test_random_frames(input int unsigned gap, input int unsigned stall,
                                    input int quota);
    int sent;
    int kind;
    int unsigned w, h, n;
    set_idling(gap, stall);
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(9);
      w = $urandom_range(3, 9);
      h = $urandom_range(3, 7);
      if (kind == 0) w = $urandom_range(0, 2);
      if (kind == 1) h = $urandom_range(1025, 2047);
      drain_and_pause();
      set_frame(SIZE_W'(w), SIZE_W'(h));
      w = clamp_size(SIZE_W'(w), LINE_DEPTH);
      h = clamp_size(SIZE_W'(h), HEIGHT_CAP);
      n = w * h;
      if (kind == 1 || kind >= 8) n = $urandom_range(1, 4 * w);  // frame cut short
      else if (kind == 2) n = 2 * n;                              // wraps into a second frame
      if (sent + int'(n) > quota) n = unsigned'(quota - sent);   // stay within the quota
      send_samples(n);
      sent += n;
    end
    drain_and_pause();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_size();
    test_directed_extremes();
    test_frame_restart();
    test_size_limits();
    test_random_frames(0, 0, 40);
    test_random_frames(71, 0, 40);
    test_random_frames(0, 71, 40);
    test_random_frames(23, 23, 40);

    drain_and_pause();
    $display("run covered %0d pixel requests and %0d result requests over %0d frame sizes",
             pixels_sent, results_checked, sizes_applied);
    $display("incl. rail samples, edge repeats, the narrow-frame cap, saturated sizes, restarts");
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d pixels never seen", mismatches, expected_pixels.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bbd_pkg.sv
rtl/core/bbd_interp.sv
rtl/core/bayer_bggr_bilinear_demosaic.sv
dv/tb.sv
